@@ rtl/core/rpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB palette color distance - shared package
// Beat types, configuration register map and fixed-point widths.
// ----------------------------------------------------------------------------
package rpcd_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam int CH_W   = 10;          // signed channel value or difference
  localparam int E_W    = 54;          // Q.32 energy
  localparam int D_W    = E_W - 32;    // integer distance before clipping
  localparam int GAP_W  = 40;          // threshold minus palette chroma, Q.32
  localparam int PEN_W  = GAP_W + 8;
  localparam int RGB_W  = 18;
  localparam int DIST_W = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PENALTY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FLOOR   = 3'd4;

  localparam logic [1:0] MODE_RGB      = 2'd0;
  localparam logic [1:0] MODE_YUV      = 2'd1;
  localparam logic [1:0] MODE_YUV_GRAY = 2'd2;

  localparam logic [1:0]        RST_MODE    = MODE_YUV_GRAY;
  localparam logic [DIST_W-1:0] RST_MAX     = 18'd262143;
  localparam logic [7:0]        RST_THRESH  = 8'd30;
  localparam logic [7:0]        RST_PENALTY = 8'd28;
  localparam logic [7:0]        RST_FLOOR   = 8'd4;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } pix_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } dist_out_t;

  typedef struct packed {
    logic [1:0]        metric_mode;
    logic [DIST_W-1:0] max_distance;
    logic [7:0]        gray_threshold;
    logic [7:0]        gray_penalty;
    logic [7:0]        chroma_floor;
  } cfg_t;

endpackage

@@ rtl/core/rpcd_cfg.sv @@
// ----------------------------------------------------------------------------
// RGB palette color distance - configuration registers
// Decodes register writes by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rpcd_cfg import rpcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.metric_mode    <= RST_MODE;
      cfg_r.max_distance   <= RST_MAX;
      cfg_r.gray_threshold <= RST_THRESH;
      cfg_r.gray_penalty   <= RST_PENALTY;
      cfg_r.chroma_floor   <= RST_FLOOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_MODE:    cfg_r.metric_mode    <= cfg_data[1:0];
        CFG_IDX_MAX:     cfg_r.max_distance   <= cfg_data[DIST_W-1:0];
        CFG_IDX_THRESH:  cfg_r.gray_threshold <= cfg_data[7:0];
        CFG_IDX_PENALTY: cfg_r.gray_penalty   <= cfg_data[7:0];
        CFG_IDX_FLOOR:   cfg_r.chroma_floor   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/rpcd_yuv_energy.sv @@
// ----------------------------------------------------------------------------
// RGB palette color distance - YUV energy pipeline
// Five stages: luma, chroma products, truncation, squares, energy sum.
// ----------------------------------------------------------------------------
module rpcd_yuv_energy import rpcd_pkg::*; #(
  parameter int FRAC      = COEF_FRAC_BITS_DEF,
  parameter bit WITH_LUMA = 1'b1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CH_W-1:0] r_i,
  input  logic signed [CH_W-1:0] g_i,
  input  logic signed [CH_W-1:0] b_i,
  output logic [E_W-1:0]         energy_o
);

  localparam int Y_W      = FRAC + 11;
  localparam int P_W      = 2 * FRAC + 11;
  localparam int M_W      = FRAC + 10;
  localparam int SQ_RAW_W = 2 * M_W;
  localparam int SQ_SHR   = (2 * FRAC >= 32) ? 2 * FRAC - 32 : 0;
  localparam int SQ_SHL   = (2 * FRAC < 32) ? 32 - 2 * FRAC : 0;

  localparam longint KYR_L = ((longint'(299) << FRAC) + 500) / 1000;
  localparam longint KYG_L = ((longint'(587) << FRAC) + 500) / 1000;
  localparam longint KYB_L = ((longint'(114) << FRAC) + 500) / 1000;
  localparam longint KCU_L = ((longint'(565) << FRAC) + 500) / 1000;
  localparam longint KCV_L = ((longint'(713) << FRAC) + 500) / 1000;

  localparam logic signed [Y_W-1:0] KYR = Y_W'(KYR_L);
  localparam logic signed [Y_W-1:0] KYG = Y_W'(KYG_L);
  localparam logic signed [Y_W-1:0] KYB = Y_W'(KYB_L);
  localparam logic signed [P_W-1:0] KCU = P_W'(KCU_L);
  localparam logic signed [P_W-1:0] KCV = P_W'(KCV_L);

  // stage 1
  logic signed [Y_W-1:0]  y1_nxt, y1_r;
  logic signed [CH_W-1:0] r1_r, b1_r;
  // stage 2
  logic signed [Y_W-1:0]  bu, rv;
  logic signed [P_W-1:0]  pu_nxt, pv_nxt, pu_r, pv_r;
  logic signed [Y_W-1:0]  y2_r;
  // stage 3
  logic [P_W-1:0]         au, av;
  logic [Y_W-1:0]         ay;
  logic [M_W-1:0]         mu_r, mv_r, my_r;
  // stage 4
  logic [SQ_RAW_W-1:0]    squ_raw, sqv_raw, sqy_raw;
  logic [E_W-1:0]         squ_r, sqv_r, sqy_r;
  // stage 5
  logic [E_W-1:0]         energy_r;

  assign y1_nxt = KYR * Y_W'(r_i) + KYG * Y_W'(g_i) + KYB * Y_W'(b_i);

  assign bu     = (Y_W'(b1_r) <<< FRAC) - y1_r;
  assign rv     = (Y_W'(r1_r) <<< FRAC) - y1_r;
  assign pu_nxt = KCU * P_W'(bu);
  assign pv_nxt = KCV * P_W'(rv);

  // truncation toward zero: take magnitude, then drop the fraction (chroma only; luma keeps its low bits)
  assign au = pu_r[P_W-1] ? P_W'(-pu_r) : P_W'(pu_r);
  assign av = pv_r[P_W-1] ? P_W'(-pv_r) : P_W'(pv_r);
  assign ay = y2_r[Y_W-1] ? Y_W'(-y2_r) : Y_W'(y2_r);

  assign squ_raw = SQ_RAW_W'(mu_r) * SQ_RAW_W'(mu_r);
  assign sqv_raw = SQ_RAW_W'(mv_r) * SQ_RAW_W'(mv_r);
  assign sqy_raw = SQ_RAW_W'(my_r) * SQ_RAW_W'(my_r);

  always_ff @(posedge clk) begin
    if (en) begin
      y1_r     <= y1_nxt;
      r1_r     <= r_i;
      b1_r     <= b_i;

      pu_r     <= pu_nxt;
      pv_r     <= pv_nxt;
      y2_r     <= y1_r;

      mu_r     <= au[FRAC +: M_W];
      mv_r     <= av[FRAC +: M_W];
      my_r     <= ay[M_W-1:0];

      squ_r    <= E_W'(squ_raw >> SQ_SHR) << SQ_SHL;
      sqv_r    <= E_W'(sqv_raw >> SQ_SHR) << SQ_SHL;
      sqy_r    <= E_W'(sqy_raw >> SQ_SHR) << SQ_SHL;

      energy_r <= squ_r + sqv_r + (WITH_LUMA ? sqy_r : '0);
    end
  end

  assign energy_o = energy_r;

endmodule

@@ rtl/core/rgb_palette_color_distance_top.sv @@
// ----------------------------------------------------------------------------
// RGB palette color distance - top level
// RGB or weighted YUV distance between a source and a palette color, with
// optional gray penalty and saturation at a programmable maximum.
//
//   channel  ports                                   handshake
//   input    in_valid  in_stall  in_data   (pix)     valid / stall
//   result   out_valid out_stall out_data  (dist)    valid / stall
//   config   cfg_valid cfg_ready cfg_index cfg_data  valid / ready
//
// One beat per cycle while the result is not stalled, through a ten-stage
// pipeline (input register, five-stage YUV energy units, penalty gate,
// penalty product, sum, clip).
// Reset (rst_n, synchronous) empties the pipeline and loads register defaults.
// A stalled result freezes the whole pipeline; in_stall follows out_stall
// only while the output register holds a beat.
// ----------------------------------------------------------------------------
module rgb_palette_color_distance_top import rpcd_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dist_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 10;

  cfg_t cfg;
  logic adv;
  logic [NSTG-1:0] vld_r;

  // stage 0
  logic signed [CH_W-1:0] dr_r, dg_r, db_r;
  logic signed [CH_W-1:0] sr_r, sg_r, sb_r;
  logic signed [CH_W-1:0] pr_r, pg_r, pb_r;
  // rgb path
  logic [RGB_W-1:0] rgb_nxt;
  logic [RGB_W-1:0] rgb_r [1:7];
  // energies from the units
  logic [E_W-1:0] dif_energy, src_chroma, pal_chroma;
  // stage 6
  logic [E_W-1:0]   thr_q, flo_q, gap_full;
  logic [E_W-1:0]   e6_r;
  logic             pen_on6_r;
  logic [GAP_W-1:0] gap6_r;
  // stage 7
  logic [E_W-1:0]   e7_r;
  logic [PEN_W-1:0] pen7_r;
  // stage 8
  logic [E_W-1:0]   total;
  logic [D_W-1:0]   d8_nxt, d8_r;
  // stage 9
  dist_out_t        out_r;

  rpcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  assign adv      = !vld_r[NSTG-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r <= $signed({2'b00, in_data.pal_red})   - $signed({2'b00, in_data.src_red});
      dg_r <= $signed({2'b00, in_data.pal_green}) - $signed({2'b00, in_data.src_green});
      db_r <= $signed({2'b00, in_data.pal_blue})  - $signed({2'b00, in_data.src_blue});
      sr_r <= $signed({2'b00, in_data.src_red});
      sg_r <= $signed({2'b00, in_data.src_green});
      sb_r <= $signed({2'b00, in_data.src_blue});
      pr_r <= $signed({2'b00, in_data.pal_red});
      pg_r <= $signed({2'b00, in_data.pal_green});
      pb_r <= $signed({2'b00, in_data.pal_blue});
    end
  end

  rpcd_yuv_energy #(.FRAC(COEF_FRAC_BITS), .WITH_LUMA(1'b1)) u_dif (
    .clk (clk), .en (adv), .r_i (dr_r), .g_i (dg_r), .b_i (db_r),
    .energy_o (dif_energy)
  );

  rpcd_yuv_energy #(.FRAC(COEF_FRAC_BITS), .WITH_LUMA(1'b0)) u_src (
    .clk (clk), .en (adv), .r_i (sr_r), .g_i (sg_r), .b_i (sb_r),
    .energy_o (src_chroma)
  );

  rpcd_yuv_energy #(.FRAC(COEF_FRAC_BITS), .WITH_LUMA(1'b0)) u_pal (
    .clk (clk), .en (adv), .r_i (pr_r), .g_i (pg_r), .b_i (pb_r),
    .energy_o (pal_chroma)
  );

  assign rgb_nxt = RGB_W'(dr_r) * RGB_W'(dr_r) + RGB_W'(dg_r) * RGB_W'(dg_r)
                 + RGB_W'(db_r) * RGB_W'(db_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_r[1] <= rgb_nxt;
      for (int i = 2; i <= 7; i++) begin
        rgb_r[i] <= rgb_r[i-1];
      end
    end
  end

  assign thr_q    = E_W'(cfg.gray_threshold) << 32;
  assign flo_q    = E_W'(cfg.chroma_floor) << 32;
  assign gap_full = thr_q - pal_chroma;

  always_ff @(posedge clk) begin
    if (adv) begin
      e6_r      <= dif_energy;
      pen_on6_r <= cfg.metric_mode[1] && (src_chroma > flo_q) && (pal_chroma < thr_q);
      gap6_r    <= gap_full[GAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e7_r   <= e6_r;
      pen7_r <= pen_on6_r ? PEN_W'(cfg.gray_penalty) * PEN_W'(gap6_r) : '0;
    end
  end

  assign total  = e7_r + E_W'(pen7_r);
  assign d8_nxt = (cfg.metric_mode == MODE_RGB) ? D_W'(rgb_r[7]) : total[E_W-1:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      d8_r <= d8_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d8_r > D_W'(cfg.max_distance)) begin
        out_r.distance  <= cfg.max_distance;
        out_r.saturated <= 1'b1;
      end else begin
        out_r.distance  <= d8_r[DIST_W-1:0];
        out_r.saturated <= 1'b0;
      end
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

endmodule
